[design/euv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euv_pkg
// Shared constants, widths and the arctangent table of the Euler rotator.
// ----------------------------------------------------------------------------
package euv_pkg;

    localparam int COORD_WIDTH_DEF     = 32;
    localparam int TRIG_ITERATIONS_DEF = 20;

    localparam int ANGLE_WIDTH  = 16;
    localparam int THRESH_WIDTH = 16;
    // folded angle, |r| <= quarter turn
    localparam int RED_WIDTH    = 14;
    // cos, sin and residual angle in Q2.30 with headroom
    localparam int TRIG_WIDTH   = 34;

    localparam logic signed [ANGLE_WIDTH:0] DEG_UNITS_TURN    = 17'sd23040;
    localparam logic signed [ANGLE_WIDTH:0] DEG_UNITS_HALF    = 17'sd11520;
    localparam logic signed [ANGLE_WIDTH:0] DEG_UNITS_QUARTER = 17'sd5760;

    // pi / 11520 in Q46
    localparam logic [34:0] RAD_SCALE = 35'd19190098069;
    // cordic gain 0.60725293 in Q30
    localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [TRIG_WIDTH-1:0] ATAN_Q30 [0:10] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576
    };

    function automatic logic signed [TRIG_WIDTH-1:0] atan_entry(input int unsigned i);
        logic signed [TRIG_WIDTH-1:0] a;
        if (i < 11) begin
            a = ATAN_Q30[i];
        end else if (i <= 30) begin
            a = TRIG_WIDTH'(64'd1 << (30 - i));
        end else begin
            a = '0;
        end
        return a;
    endfunction

endpackage
`default_nettype wire

[design/euv_trig.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euv_trig
// Pipelined cosine and sine of three folded angles: radian scaling, one
// cordic iteration per stage, then sign restore of folded angles.
// ----------------------------------------------------------------------------
module euv_trig #(
    parameter int TRIG_ITERATIONS = euv_pkg::TRIG_ITERATIONS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic [TRIG_ITERATIONS+1:0]           en,
    input  wire logic signed [euv_pkg::RED_WIDTH-1:0] red_in [0:2],
    input  wire logic [2:0]                           neg_in,
    output logic signed [euv_pkg::TRIG_WIDTH-1:0]     cos_out [0:2],
    output logic signed [euv_pkg::TRIG_WIDTH-1:0]     sin_out [0:2]
);

    localparam int N  = TRIG_ITERATIONS;
    localparam int TW = euv_pkg::TRIG_WIDTH;
    localparam int PW = euv_pkg::RED_WIDTH + 36;

    logic signed [TW-1:0] x_reg [0:N][0:2];
    logic signed [TW-1:0] y_reg [0:N][0:2];
    logic signed [TW-1:0] z_reg [0:N][0:2];
    logic [2:0]           neg_reg [0:N];
    logic signed [TW-1:0] cos_reg [0:2];
    logic signed [TW-1:0] sin_reg [0:2];

    logic signed [PW-1:0] prod [0:2];

    // radians in Q2.30, round half up
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod[a] = PW'(red_in[a]) * PW'($signed({1'b0, euv_pkg::RAD_SCALE}));
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int a = 0; a < 3; a++) begin
                x_reg[0][a] <= euv_pkg::CORDIC_GAIN;
                y_reg[0][a] <= '0;
                z_reg[0][a] <= TW'((prod[a] + PW'(1 << 15)) >>> 16);
            end
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [TW-1:0] ATAN_I = euv_pkg::atan_entry(i);
        always_ff @(posedge aclk) begin
            if (en[i+1]) begin
                for (int a = 0; a < 3; a++) begin
                    if (!z_reg[i][a][TW-1]) begin
                        x_reg[i+1][a] <= x_reg[i][a] - (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] + (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] - ATAN_I;
                    end else begin
                        x_reg[i+1][a] <= x_reg[i][a] + (y_reg[i][a] >>> i);
                        y_reg[i+1][a] <= y_reg[i][a] - (x_reg[i][a] >>> i);
                        z_reg[i+1][a] <= z_reg[i][a] + ATAN_I;
                    end
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // folded angles get both values negated
    always_ff @(posedge aclk) begin
        if (en[N+1]) begin
            for (int a = 0; a < 3; a++) begin
                cos_reg[a] <= neg_reg[N][a] ? -x_reg[N][a] : x_reg[N][a];
                sin_reg[a] <= neg_reg[N][a] ? -y_reg[N][a] : y_reg[N][a];
            end
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule
`default_nettype wire

[design/euv_rot.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euv_rot
// Two-stage planar rotation of one coordinate pair about axis AXIS:
// magnitude products, then rounding and combine. Other fields pass along.
// ----------------------------------------------------------------------------
module euv_rot #(
    parameter int COORD_WIDTH = euv_pkg::COORD_WIDTH_DEF,
    parameter int AXIS        = 0
) (
    input  wire logic                                aclk,
    input  wire logic [1:0]                          en,
    input  wire logic signed [COORD_WIDTH+1:0]       vec_in  [0:2],
    input  wire logic signed [euv_pkg::TRIG_WIDTH-1:0] cos_in [0:2],
    input  wire logic signed [euv_pkg::TRIG_WIDTH-1:0] sin_in [0:2],
    input  wire logic [2:0]                          nz_in,
    output logic signed [COORD_WIDTH+1:0]            vec_out [0:2],
    output logic signed [euv_pkg::TRIG_WIDTH-1:0]    cos_out [0:2],
    output logic signed [euv_pkg::TRIG_WIDTH-1:0]    sin_out [0:2],
    output logic [2:0]                               nz_out
);

    localparam int WW  = COORD_WIDTH + 2;
    localparam int TW  = euv_pkg::TRIG_WIDTH;
    localparam int PRW = WW + TW;
    localparam int SW  = PRW - 28;
    localparam int PI  = (AXIS + 1) % 3;
    localparam int QI  = (AXIS + 2) % 3;

    logic signed [WW-1:0] vec1_reg [0:2];
    logic signed [TW-1:0] cos1_reg [0:2];
    logic signed [TW-1:0] sin1_reg [0:2];
    logic [2:0]           nz1_reg;
    logic [PRW-1:0]       pc_reg, qs_reg, ps_reg, qc_reg;
    logic                 pc_neg_reg, qs_neg_reg, ps_neg_reg, qc_neg_reg;

    logic signed [WW-1:0] vec2_reg [0:2];
    logic signed [TW-1:0] cos2_reg [0:2];
    logic signed [TW-1:0] sin2_reg [0:2];
    logic [2:0]           nz2_reg;

    logic signed [WW-1:0] p, q;
    logic signed [TW-1:0] c, s;
    logic [WW-1:0]        mp, mq;
    logic [TW-1:0]        mc, ms;
    logic signed [SW-1:0] np, nq;

    // product magnitude rounded half away from zero, sign restored
    function automatic logic signed [SW-1:0] rnd(input logic [PRW-1:0] pr, input logic ng);
        logic [PRW-1:0] t;
        t = (pr + PRW'(1 << 29)) >> 30;
        return ng ? -SW'(t) : SW'(t);
    endfunction

    always_comb begin
        p  = vec_in[PI];
        q  = vec_in[QI];
        c  = cos_in[AXIS];
        s  = sin_in[AXIS];
        mp = WW'(p[WW-1] ? -p : p);
        mq = WW'(q[WW-1] ? -q : q);
        mc = TW'(c[TW-1] ? -c : c);
        ms = TW'(s[TW-1] ? -s : s);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            vec1_reg   <= vec_in;
            cos1_reg   <= cos_in;
            sin1_reg   <= sin_in;
            nz1_reg    <= nz_in;
            pc_reg     <= PRW'(mp) * PRW'(mc);
            qs_reg     <= PRW'(mq) * PRW'(ms);
            ps_reg     <= PRW'(mp) * PRW'(ms);
            qc_reg     <= PRW'(mq) * PRW'(mc);
            pc_neg_reg <= p[WW-1] ^ c[TW-1];
            qs_neg_reg <= q[WW-1] ^ s[TW-1];
            ps_neg_reg <= p[WW-1] ^ s[TW-1];
            qc_neg_reg <= q[WW-1] ^ c[TW-1];
        end
    end

    always_comb begin
        np = rnd(pc_reg, pc_neg_reg) - rnd(qs_reg, qs_neg_reg);
        nq = rnd(ps_reg, ps_neg_reg) + rnd(qc_reg, qc_neg_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            // zero angle leaves the pair untouched
            for (int a = 0; a < 3; a++) begin
                if (nz1_reg[AXIS] && a == PI) begin
                    vec2_reg[a] <= WW'(np);
                end else if (nz1_reg[AXIS] && a == QI) begin
                    vec2_reg[a] <= WW'(nq);
                end else begin
                    vec2_reg[a] <= vec1_reg[a];
                end
            end
            cos2_reg <= cos1_reg;
            sin2_reg <= sin1_reg;
            nz2_reg  <= nz1_reg;
        end
    end

    assign vec_out = vec2_reg;
    assign cos_out = cos2_reg;
    assign sin_out = sin2_reg;
    assign nz_out  = nz2_reg;

endmodule
`default_nettype wire

[design/euler_vector_rotate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euler_vector_rotate
// Rotates a fixed-point 3D vector about X, then Y, then Z by Euler angles.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one vector and three angles per transaction (tdata fields
//   below). m_ channel: rotated vector plus a saturation flag.
//   cfg channel: writes snap_threshold; always ready, write only while idle.
// Throughput: one transaction per cycle while the output is not stalled; the
//   chain is angle folding, radian scaling, one cordic iteration per stage,
//   sign restore, three two-stage rotations and a saturate/snap output
//   register.
// Stall: every stage holds its own valid bit; while m_tready is low the
//   pipe keeps filling its empty stages and s_tready drops only once every
//   stage holds a transaction. Nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the pipe and sets
//   snap_threshold to 1.
// ----------------------------------------------------------------------------
module euler_vector_rotate #(
    parameter int COORD_WIDTH     = euv_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_ITERATIONS = euv_pkg::TRIG_ITERATIONS_DEF,
    localparam int IN_W  = ((3 * COORD_WIDTH + 3 * euv_pkg::ANGLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_WIDTH + 1 + 7) / 8) * 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // coord_x, coord_y, coord_z, angle_x, angle_y, angle_z
    input  wire logic [IN_W-1:0]                   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // rotated_x, rotated_y, rotated_z, saturated, zero pad
    output logic [OUT_W-1:0]                       m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [euv_pkg::THRESH_WIDTH-1:0]  cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int N  = TRIG_ITERATIONS;
    localparam int WW = CW + 2;
    localparam int TW = euv_pkg::TRIG_WIDTH;
    localparam int AW = euv_pkg::ANGLE_WIDTH;
    localparam int RW = euv_pkg::RED_WIDTH;
    localparam int L  = N + 10;
    localparam int TS = N + 2;

    localparam logic signed [WW-1:0] HI = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [WW-1:0] LO = {3'b111, {(CW-1){1'b0}}};

    logic [euv_pkg::THRESH_WIDTH-1:0] thresh_reg;
    logic [L-1:0]                     v_reg;
    logic [L:0]                       en;

    logic signed [WW-1:0] crd_reg [0:TS][0:2];
    logic [2:0]           nz_reg  [0:TS];
    logic signed [RW-1:0] red_reg [0:2];
    logic [2:0]           neg_reg;

    logic signed [RW-1:0] red_next [0:2];
    logic [2:0]           neg_next;
    logic [2:0]           nz_next;

    logic signed [TW-1:0] cos_t [0:2];
    logic signed [TW-1:0] sin_t [0:2];
    logic signed [WW-1:0] vec_a [0:2];
    logic signed [WW-1:0] vec_b [0:2];
    logic signed [WW-1:0] vec_c [0:2];
    logic signed [TW-1:0] cos_a [0:2];
    logic signed [TW-1:0] sin_a [0:2];
    logic signed [TW-1:0] cos_b [0:2];
    logic signed [TW-1:0] sin_b [0:2];
    logic signed [TW-1:0] cos_c [0:2];
    logic signed [TW-1:0] sin_c [0:2];
    logic [2:0]           nz_a, nz_b, nz_c;

    logic [CW-1:0]        res_next [0:2];
    logic [CW-1:0]        res_reg  [0:2];
    logic                 sat_next, sat_reg;
    logic signed [WW-1:0] thr_w;

    // angle reduced to one turn, then to half a turn, then folded to a quarter
    function automatic logic [RW:0] fold_angle(input logic signed [AW-1:0] ang);
        logic signed [AW:0] u;
        logic               ng;
        u  = (AW+1)'(ang);
        ng = 1'b0;
        if (u < 0) begin
            u = u + euv_pkg::DEG_UNITS_TURN;
        end
        if (u < 0) begin
            u = u + euv_pkg::DEG_UNITS_TURN;
        end
        if (u >= euv_pkg::DEG_UNITS_TURN) begin
            u = u - euv_pkg::DEG_UNITS_TURN;
        end
        if (u > euv_pkg::DEG_UNITS_HALF) begin
            u = u - euv_pkg::DEG_UNITS_TURN;
        end
        if (u > euv_pkg::DEG_UNITS_QUARTER) begin
            u  = u - euv_pkg::DEG_UNITS_HALF;
            ng = 1'b1;
        end else if (u < -euv_pkg::DEG_UNITS_QUARTER) begin
            u  = u + euv_pkg::DEG_UNITS_HALF;
            ng = 1'b1;
        end
        return {ng, u[RW-1:0]};
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= euv_pkg::THRESH_WIDTH'(1);
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    // a stage loads when it is empty or its successor loads
    assign en[L] = m_tready;
    for (genvar k = 0; k < L; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < L; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[L-1];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            {neg_next[a], red_next[a]} = fold_angle(s_tdata[3*CW + a*AW +: AW]);
            nz_next[a] = s_tdata[3*CW + a*AW +: AW] != '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int a = 0; a < 3; a++) begin
                crd_reg[0][a] <= WW'($signed(s_tdata[a*CW +: CW]));
            end
            red_reg   <= red_next;
            neg_reg   <= neg_next;
            nz_reg[0] <= nz_next;
        end
        for (int k = 1; k <= TS; k++) begin
            if (en[k]) begin
                crd_reg[k] <= crd_reg[k-1];
                nz_reg[k]  <= nz_reg[k-1];
            end
        end
    end

    euv_trig #(
        .TRIG_ITERATIONS(N)
    ) u_trig (
        .aclk    (aclk),
        .en      (en[TS:1]),
        .red_in  (red_reg),
        .neg_in  (neg_reg),
        .cos_out (cos_t),
        .sin_out (sin_t)
    );

    euv_rot #(.COORD_WIDTH(CW), .AXIS(0)) u_rot_x (
        .aclk (aclk), .en (en[TS+2:TS+1]),
        .vec_in (crd_reg[TS]), .cos_in (cos_t), .sin_in (sin_t), .nz_in (nz_reg[TS]),
        .vec_out (vec_a), .cos_out (cos_a), .sin_out (sin_a), .nz_out (nz_a)
    );

    euv_rot #(.COORD_WIDTH(CW), .AXIS(1)) u_rot_y (
        .aclk (aclk), .en (en[TS+4:TS+3]),
        .vec_in (vec_a), .cos_in (cos_a), .sin_in (sin_a), .nz_in (nz_a),
        .vec_out (vec_b), .cos_out (cos_b), .sin_out (sin_b), .nz_out (nz_b)
    );

    euv_rot #(.COORD_WIDTH(CW), .AXIS(2)) u_rot_z (
        .aclk (aclk), .en (en[TS+6:TS+5]),
        .vec_in (vec_b), .cos_in (cos_b), .sin_in (sin_b), .nz_in (nz_b),
        .vec_out (vec_c), .cos_out (cos_c), .sin_out (sin_c), .nz_out (nz_c)
    );

    // a clipped component is never snapped
    always_comb begin
        thr_w    = WW'($signed({1'b0, thresh_reg}));
        sat_next = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (vec_c[a] > HI) begin
                res_next[a] = HI[CW-1:0];
                sat_next    = 1'b1;
            end else if (vec_c[a] < LO) begin
                res_next[a] = LO[CW-1:0];
                sat_next    = 1'b1;
            end else if (vec_c[a] < thr_w && vec_c[a] > -thr_w) begin
                res_next[a] = '0;
            end else begin
                res_next[a] = vec_c[a][CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[L-1]) begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign m_tdata = OUT_W'({sat_reg, res_reg[2], res_reg[1], res_reg[0]});

endmodule
`default_nettype wire

[design/euv_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euv_checker
// Port-level checks of the Euler rotator, bound to the top level.
// ----------------------------------------------------------------------------
module euv_checker #(
    parameter int COORD_WIDTH = euv_pkg::COORD_WIDTH_DEF,
    parameter int OUT_W       = ((3 * COORD_WIDTH + 1 + 7) / 8) * 8
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    localparam int CW = COORD_WIDTH;
    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // the flag is only raised with at least one component at a limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3*CW] |->
            (m_tdata[CW-1:0] == MAXV) || (m_tdata[CW-1:0] == MINV) ||
            (m_tdata[2*CW-1:CW] == MAXV) || (m_tdata[2*CW-1:CW] == MINV) ||
            (m_tdata[3*CW-1:2*CW] == MAXV) || (m_tdata[3*CW-1:2*CW] == MINV))
        else $error("saturation flag without a clipped component");

endmodule

bind euler_vector_rotate euv_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_euv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
